### rtl/core/ctmf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctmf_pkg
// Shared widths and types for the circular trimmed mean filter.
// ----------------------------------------------------------------------------
package ctmf_pkg;

  // fixed field widths of the channels
  localparam int SAMPLE_W = 18;
  localparam int MEAN_W   = 17;

  // status of the job queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } ctmf_q_stat_t;

endpackage : ctmf_pkg
`default_nettype wire

### rtl/core/ctmf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctmf channel interfaces
// Valid/ready channels for angle samples and trimmed mean results.
// ----------------------------------------------------------------------------

// sample channel
interface ctmf_in_if import ctmf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] angle_sample;

  modport source (output valid, output angle_sample, input ready);
  modport sink   (input valid, input angle_sample, output ready);
endinterface : ctmf_in_if

// result channel
interface ctmf_out_if import ctmf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean_angle;
  logic                     fold_applied;

  modport source (output valid, output mean_angle, output fold_applied, input ready);
  modport sink   (input valid, input mean_angle, input fold_applied, output ready);
endinterface : ctmf_out_if
`default_nettype wire

### rtl/core/ctmf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctmf_queue
// Small register queue carrying trimmed-sum jobs from front to back.
// ----------------------------------------------------------------------------
module ctmf_queue import ctmf_pkg::*; #(
  parameter int DATA_W = 22,
  parameter int DEPTH  = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic      [DATA_W-1:0] pop_data,
  output ctmf_q_stat_t           stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  // status toward both sides
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !stat.full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !stat.empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !stat.full) && !(pop && !stat.empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !stat.full) && (pop && !stat.empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : ctmf_queue
`default_nettype wire

### rtl/core/ctmf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctmf_front
// Accepts samples, keeps the window and its sorted image, tests the fold
// and accumulates the trimmed sum in rotated order.
// ----------------------------------------------------------------------------
module ctmf_front import ctmf_pkg::*; #(
  parameter int WINDOW_DEPTH = 16,
  parameter int TRIM_COUNT   = 4,
  parameter int ANGLE_BITS   = 16,
  parameter int SUM_W        = ANGLE_BITS + 1 + $clog2(WINDOW_DEPTH)
) (
  input  wire logic         clk,
  input  wire logic         rst,
  ctmf_in_if.sink           sample_ch,
  input  ctmf_q_stat_t      q_stat,
  output logic              push,
  output logic [SUM_W:0]    push_data
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FOLD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  localparam logic signed [ANGLE_BITS-1:0] NEG_HALF = {2'b11, {(ANGLE_BITS-2){1'b0}}};
  localparam logic signed [ANGLE_BITS-1:0] POS_HALF = {2'b01, {(ANGLE_BITS-2){1'b0}}};
  localparam logic signed [SUM_W-1:0]      TWO_PI   =
    {{(SUM_W-ANGLE_BITS-1){1'b0}}, 1'b1, {ANGLE_BITS{1'b0}}};

  logic [1:0]                   state;
  logic                         accept;

  // window memory with per-entry valid bits
  logic signed [ANGLE_BITS-1:0] win [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]      win_vld;
  logic [IDX_W-1:0]             slot;
  logic signed [ANGLE_BITS-1:0] old_q;

  // sorted image of the window
  logic signed [ANGLE_BITS-1:0] sorted [WINDOW_DEPTH];
  logic signed [ANGLE_BITS-1:0] ins    [WINDOW_DEPTH];
  logic signed [ANGLE_BITS-1:0] trimmed[WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]      ge;
  logic [WINDOW_DEPTH-1:0]      lt;
  logic signed [ANGLE_BITS-1:0] x;
  logic signed [63:0]           sample_ext;

  // fold test
  logic [WINDOW_DEPTH-1:0]      neg;
  logic                         fold_c;
  logic [IDX_W-1:0]             rot_c;
  logic                         fold_r;
  logic [IDX_W-1:0]             rot_r;

  // trimmed sum
  logic [IDX_W-1:0]             cnt;
  logic [IDX_W:0]               rank;
  logic                         keep_hit;
  logic signed [SUM_W-1:0]      term;
  logic signed [SUM_W-1:0]      acc;

  assign sample_ch.ready = (state == ST_IDLE);
  assign accept          = sample_ch.valid && sample_ch.ready;

  // wrap into the angle width
  assign sample_ext = 64'(sample_ch.angle_sample);
  assign x          = sample_ext[ANGLE_BITS-1:0];

  // remove the oldest value, then insert the new one
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      ge[i] = (sorted[i] >= old_q);
    end
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (i < WINDOW_DEPTH - 1) begin
        trimmed[i] = ge[i] ? sorted[i+1] : sorted[i];
        lt[i]      = (trimmed[i] < x);
      end else begin
        trimmed[i] = sorted[i];
        lt[i]      = 1'b0;
      end
    end
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (i == 0) begin
        ins[i] = lt[i] ? trimmed[i] : x;
      end else begin
        ins[i] = lt[i] ? trimmed[i] : (lt[i-1] ? x : trimmed[i-1]);
      end
    end
  end

  // seam test and rotation point
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      neg[i] = (sorted[i] < NEG_HALF);
    end
    fold_c = neg[0] && (sorted[WINDOW_DEPTH-1] > POS_HALF);
    rot_c  = '0;
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      if (neg[i-1] && !neg[i]) begin
        rot_c = rot_c | IDX_W'(i);
      end
    end
    if (!fold_c) begin
      rot_c = '0;
    end
  end

  // rank of the element at the head of the rotating image
  always_comb begin
    if (cnt >= rot_r) begin
      rank = {1'b0, cnt} - {1'b0, rot_r};
    end else begin
      rank = {1'b0, cnt} + (IDX_W+1)'(WINDOW_DEPTH) - {1'b0, rot_r};
    end
    keep_hit = (int'(rank) >= TRIM_COUNT) &&
               (int'(rank) <= WINDOW_DEPTH - 1 - TRIM_COUNT);
    term = SUM_W'(sorted[0]);
    if (fold_r && neg[0]) begin
      term = term + TWO_PI;
    end
  end

  assign push      = (state == ST_PUSH) && !q_stat.full;
  assign push_data = {fold_r, acc};

  // window memory
  always_ff @(posedge clk) begin
    if (accept) begin
      win[slot] <= x;
    end
  end

  // valid bits, slot and oldest-value read
  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld <= '0;
      slot    <= '0;
      old_q   <= '0;
    end else begin
      old_q <= win_vld[slot] ? win[slot] : '0;
      if (accept) begin
        win_vld[slot] <= 1'b1;
        slot          <= (slot == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot + 1'b1;
      end
    end
  end

  // sorted image: insert on accept, rotate during the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        sorted[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        sorted[i] <= ins[i];
      end
    end else if (state == ST_SCAN) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        sorted[i] <= sorted[i+1];
      end
      sorted[WINDOW_DEPTH-1] <= sorted[0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) state <= ST_FOLD;
        end
        ST_FOLD: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cnt == IDX_W'(WINDOW_DEPTH - 1)) state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!q_stat.full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (state == ST_FOLD) begin
      fold_r <= fold_c;
      rot_r  <= rot_c;
      cnt    <= '0;
      acc    <= '0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + 1'b1;
      if (keep_hit) begin
        acc <= acc + term;
      end
    end
  end

endmodule : ctmf_front
`default_nettype wire

### rtl/core/ctmf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctmf_back
// Divides each trimmed sum by the kept count through a reciprocal multiply
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module ctmf_back import ctmf_pkg::*; #(
  parameter int WINDOW_DEPTH = 16,
  parameter int TRIM_COUNT   = 4,
  parameter int ANGLE_BITS   = 16,
  parameter int SUM_W        = ANGLE_BITS + 1 + $clog2(WINDOW_DEPTH)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [SUM_W:0] job,
  input  ctmf_q_stat_t        q_stat,
  output logic                pop,
  ctmf_out_if.source          result_ch
);

  localparam int KEEP    = WINDOW_DEPTH - 2 * TRIM_COUNT;
  localparam int DIV     = (KEEP > 0) ? KEEP : 1;
  localparam int QW      = ANGLE_BITS;
  localparam int SHIFT   = SUM_W + $clog2(DIV);
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  // reciprocal of the kept count, rounded up, exact over the whole sum range
  localparam logic [63:0]        RECIP_64 = ((64'd1 << SHIFT) + 64'(DIV - 1)) / 64'(DIV);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_64[RECIP_W-1:0];

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_MUL  = 2'd1;
  localparam logic [1:0] BK_DONE = 2'd2;

  logic [1:0]              state;
  logic signed [SUM_W-1:0] job_sum;
  logic [SUM_W-1:0]        mag;
  logic [SUM_W-1:0]        mag_r;
  logic [PROD_W-1:0]       prod;
  logic [QW-1:0]           dq;
  logic                    neg_r;
  logic                    fold_r;
  logic signed [QW:0]      quot;
  logic signed [63:0]      quot_ext;
  logic                    out_free;

  assign job_sum = job[SUM_W-1:0];
  assign mag     = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : SUM_W'(job_sum);
  assign pop     = (state == BK_IDLE) && !q_stat.empty;

  // quotient magnitude from the scaled product
  assign dq = prod[SHIFT +: QW];

  // signed quotient, truncated toward zero
  assign quot     = neg_r ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  assign quot_ext = 64'(quot);
  assign out_free = !result_ch.valid || result_ch.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      unique case (state)
        BK_IDLE: begin
          if (!q_stat.empty) state <= BK_MUL;
        end
        BK_MUL: begin
          state <= BK_DONE;
        end
        BK_DONE: begin
          if (out_free) state <= BK_IDLE;
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      mag_r  <= mag;
      neg_r  <= job_sum[SUM_W-1];
      fold_r <= job[SUM_W];
    end else if (state == BK_MUL) begin
      prod <= PROD_W'(mag_r) * PROD_W'(RECIP);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_ch.valid <= 1'b0;
    end else if (state == BK_DONE && out_free) begin
      result_ch.valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_ch.valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == BK_DONE && out_free) begin
      result_ch.mean_angle   <= quot_ext[MEAN_W-1:0];
      result_ch.fold_applied <= fold_r;
    end
  end

endmodule : ctmf_back
`default_nettype wire

### rtl/core/circular_trimmed_mean_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_trimmed_mean_filter
// Sliding-window trimmed mean of angles with a fold at the +-pi seam.
// ----------------------------------------------------------------------------
//
//  channel     dir   beat fields                      role
//  sample_ch   sink  angle_sample (18 signed)         one angle per beat
//  result_ch   src   mean_angle (17 signed),          one mean per sample beat
//                    fold_applied (1)
//
//  The front takes no new sample until it is through with the last one:
//  an insert, a fold test, a trimmed-sum accumulation over the rotating
//  sorted window, and a queue push that waits while the queue is full.
//  The back takes three steps per job (pop, reciprocal multiply for the
//  kept-count divide, result load), overlapping the next front job through
//  a two-entry job queue.
//  Reset is synchronous; the window reads as zero until written, no clearing pass.
//  A stalled result holds in the output register; the queue absorbs two jobs
//  before the front stops taking samples.
//
module circular_trimmed_mean_filter import ctmf_pkg::*; #(
  parameter int WINDOW_DEPTH = 16,
  parameter int TRIM_COUNT   = 4,
  parameter int ANGLE_BITS   = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ctmf_in_if.sink     sample_ch,
  ctmf_out_if.source  result_ch
);

  localparam int SUM_W = ANGLE_BITS + 1 + $clog2(WINDOW_DEPTH);

  logic           push;
  logic [SUM_W:0] push_data;
  logic           pop;
  logic [SUM_W:0] pop_data;
  ctmf_q_stat_t   q_stat;

  // sample intake, sorting and trimmed sum
  ctmf_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TRIM_COUNT   (TRIM_COUNT),
    .ANGLE_BITS   (ANGLE_BITS),
    .SUM_W        (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // job queue
  ctmf_queue #(
    .DATA_W (SUM_W + 1),
    .DEPTH  (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // division and result register
  ctmf_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TRIM_COUNT   (TRIM_COUNT),
    .ANGLE_BITS   (ANGLE_BITS),
    .SUM_W        (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (pop_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .result_ch (result_ch)
  );

endmodule : circular_trimmed_mean_filter
`default_nettype wire

### rtl/core/ctmf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctmf_checker
// Port-level checks on result ordering, occupancy and result range.
// ----------------------------------------------------------------------------
module ctmf_checker import ctmf_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [MEAN_W-1:0] mean_angle,
  input wire logic              fold_applied
);

  localparam logic [2:0] MAX_PENDING = 3'd5;

  logic [2:0] pending;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // samples accepted whose result is not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_beat && !out_beat) begin
      pending <= pending + 1'b1;
    end else if (!in_beat && out_beat) begin
      pending <= pending - 1'b1;
    end
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mean_angle) && $stable(fold_applied))
    else $error("result changed while stalled");

  // no result without a sample behind it
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> pending != 3'd0)
    else $error("result beat without pending sample");

  // front, queue, divider and output register bound the occupancy
  a_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= MAX_PENDING)
    else $error("too many samples in flight");

  // an unfolded mean stays within the half-open pi range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fold_applied && (ANGLE_BITS <= 16) |-> mean_angle[16] == mean_angle[15])
    else $error("unfolded mean outside angle range");

endmodule : ctmf_checker

bind circular_trimmed_mean_filter ctmf_checker #(
  .ANGLE_BITS (ANGLE_BITS)
) u_ctmf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample_ch.valid),
  .in_ready     (sample_ch.ready),
  .out_valid    (result_ch.valid),
  .out_ready    (result_ch.ready),
  .mean_angle   (result_ch.mean_angle),
  .fold_applied (result_ch.fold_applied)
);
`default_nettype wire
